// ----- hw/rtl/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types, constants and slot table for the triple coverage swap evaluator
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int MAX_ROWS     = 24;
    localparam int MAX_COLUMNS  = 32;
    localparam int TRIPLE_DEPTH = 2024;
    localparam int COUNT_W      = 6;
    localparam int SLOT_W       = 11;
    localparam int ROW_W        = 5;
    localparam int COL_W        = 5;
    localparam int TOTAL_W      = 16;
    localparam int DV_W         = 10;

    // operation codes carried in tuser
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_SWAP  = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MASK,
        ST_LOAD,
        ST_EVAL,
        ST_EVDRAIN,
        ST_DECIDE,
        ST_APPLY,
        ST_DRAIN,
        ST_DONE
    } tcs_state_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [COL_W-1:0]    column;
        logic [ROW_W-1:0]    row_out;
        logic [ROW_W-1:0]    row_in;
        logic [MAX_ROWS-1:0] mask;
        logic [15:0]         accept_limit;
    } tcs_req_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] violations;
        logic [8:0]         delta;
        logic               accepted;
        logic               status;
    } tcs_res_t;

    // binomial tables: n choose 3 and n choose 2
    localparam logic [SLOT_W-1:0] C3_TBL [32] = '{
        11'd0, 11'd0, 11'd0, 11'd1, 11'd4, 11'd10, 11'd20, 11'd35,
        11'd56, 11'd84, 11'd120, 11'd165, 11'd220, 11'd286, 11'd364, 11'd455,
        11'd560, 11'd680, 11'd816, 11'd969, 11'd1140, 11'd1330, 11'd1540, 11'd1771,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0
    };
    localparam logic [SLOT_W-1:0] C2_TBL [32] = '{
        11'd0, 11'd0, 11'd1, 11'd3, 11'd6, 11'd10, 11'd15, 11'd21,
        11'd28, 11'd36, 11'd45, 11'd55, 11'd66, 11'd78, 11'd91, 11'd105,
        11'd120, 11'd136, 11'd153, 11'd171, 11'd190, 11'd210, 11'd231, 11'd253,
        11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0
    };

    // slot of sorted triple x < y < z
    function automatic logic [SLOT_W-1:0] tcs_slot(
        input logic [ROW_W-1:0] x,
        input logic [ROW_W-1:0] y,
        input logic [ROW_W-1:0] z
    );
        tcs_slot = C3_TBL[z] + C2_TBL[y] + {{(SLOT_W-ROW_W){1'b0}}, x};
    endfunction

endpackage

// ----- hw/rtl/triple_coverage_swap_evaluator.sv -----
// One request at a time; the next is taken the cycle after the result enters
// the output register. The count memory port paces the work at one count per
// cycle: clear and load sweep all 2024 slots, while a swap reads 552 counts to
// evaluate and 552 more to apply. Rejected swaps, reloads and unknown operations
// skip the count memory.
// Reset: asynchronous; a clearing pass of the count memory follows.
// ----------------------------------------------------------------------------
// triple_coverage_swap_evaluator
// Row triple coverage store with swap evaluation and output register
// ----------------------------------------------------------------------------
module triple_coverage_swap_evaluator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // column, row_out, row_in, mask, accept_limit, zero pad
    input  logic [55:0] s_axis_tdata,
    // operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // violations, delta, accepted, status, zero pad
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import tcs_pkg::*;

    logic [ROW_W-1:0] row_count_reg;
    logic [ROW_W-1:0] rows;
    tcs_req_t         req;
    tcs_res_t         res;
    logic             res_valid, res_ready;
    logic             out_vld_reg;
    tcs_res_t         out_reg;

    // request unpack
    assign req.op           = s_axis_tuser;
    assign req.column       = s_axis_tdata[4:0];
    assign req.row_out      = s_axis_tdata[9:5];
    assign req.row_in       = s_axis_tdata[14:10];
    assign req.mask         = s_axis_tdata[38:15];
    assign req.accept_limit = s_axis_tdata[54:39];

    // row count register
    assign cfg_ready = 1'b1;
    assign rows = (row_count_reg > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : row_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_W'(MAX_ROWS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            row_count_reg <= cfg_data;
        end
    end

    tcs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .rows      (rows),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !out_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_vld_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {5'd0, out_reg.status, out_reg.accepted,
                            out_reg.delta, out_reg.violations};

`ifndef NO_ASSERTIONS
    // an applied swap is never flagged as rejected
    a_acc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[25] && m_axis_tdata[26]))
        else $error("accepted swap carries reject status");

    // rejected requests report no violation change
    a_rej_delta: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[26]) |-> (m_axis_tdata[24:16] == 9'd0))
        else $error("rejected request with nonzero delta");

    // one request in flight at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");
`endif

endmodule

// ----- hw/rtl/tcs_ram.sv -----
// ----------------------------------------------------------------------------
// tcs_ram
// Simple dual-port RAM, one write port and one registered read port
// ----------------------------------------------------------------------------
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hw/rtl/tcs_engine.sv -----
// ----------------------------------------------------------------------------
// tcs_engine
// Sequencer over the column mask and triple count memories
// ----------------------------------------------------------------------------
module tcs_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  tcs_pkg::tcs_req_t      req,
    input  logic [tcs_pkg::ROW_W-1:0] rows,
    output logic                   res_valid,
    input  logic                   res_ready,
    output tcs_pkg::tcs_res_t      res
);
    import tcs_pkg::*;

    tcs_state_t state_reg, state_next;

    logic [SLOT_W-1:0]   idx_reg;
    logic [ROW_W-1:0]    x_reg, y_reg, z_reg;
    logic [ROW_W-1:0]    a_reg, b_reg;
    logic                sel_reg;
    logic                p1_vld_reg, p1_hit_reg, p1_sel_reg;
    logic [SLOT_W-1:0]   p1_addr_reg;
    logic                apply_reg;
    logic                clr_res_reg;
    logic [1:0]          op_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    rout_reg, rin_reg;
    logic [MAX_ROWS-1:0] mask_reg;
    logic [15:0]         limit_reg;
    logic [MAX_COLUMNS-1:0] loaded_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [DV_W-1:0]     dv_reg;
    logic                status_reg, acc_reg;

    logic                cnt_wr_en;
    logic [SLOT_W-1:0]   cnt_wr_addr, cnt_rd_addr;
    logic [COUNT_W-1:0]  cnt_wr_data, cnt_rd_data;
    logic                msk_wr_en;
    logic [MAX_ROWS-1:0] msk_wr_data, msk_rd_data;
    logic [COL_W-1:0]    msk_wr_addr;

    logic [MAX_ROWS-1:0] valid_rows;
    logic [MAX_ROWS-1:0] col_mask;
    logic [31:0]         col_mask_w;
    logic                swap_bad;
    logic                accept_req;
    logic                issue, last_issue;
    logic                load_hit, swap_hit;
    logic [ROW_W-1:0]    r_sel;
    logic [SLOT_W-1:0]   swap_addr;
    logic [COUNT_W-1:0]  cnt_inc, cnt_dec;
    logic                take_swap;
    logic [MAX_ROWS-1:0] rin_bit;

    // triple count store and column mask store
    tcs_ram #(.WIDTH(COUNT_W), .DEPTH(TRIPLE_DEPTH)) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    tcs_ram #(.WIDTH(MAX_ROWS), .DEPTH(MAX_COLUMNS)) u_msk_ram (
        .clk     (clk),
        .wr_en   (msk_wr_en),
        .wr_addr (msk_wr_addr),
        .wr_data (msk_wr_data),
        .rd_addr (req.column),
        .rd_data (msk_rd_data)
    );

    // row limits and swap legality
    assign valid_rows = MAX_ROWS'((25'd1 << rows) - 25'd1);
    assign col_mask   = loaded_reg[col_reg] ? msk_rd_data : '0;
    assign col_mask_w = {{(32-MAX_ROWS){1'b0}}, col_mask};
    assign swap_bad   = (rout_reg >= rows) || (rin_reg >= rows) ||
                        !col_mask_w[rout_reg] || col_mask_w[rin_reg];
    assign accept_req = req_valid && req_ready;
    assign rin_bit    = MAX_ROWS'(1) << rin_reg;

    // walk address generation
    assign r_sel = sel_reg ? rin_reg : rout_reg;
    always_comb
    begin
        if (r_sel < a_reg)
        begin
            swap_addr = tcs_slot(r_sel, a_reg, b_reg);
        end
        else if (r_sel < b_reg)
        begin
            swap_addr = tcs_slot(a_reg, r_sel, b_reg);
        end
        else
        begin
            swap_addr = tcs_slot(a_reg, b_reg, r_sel);
        end
    end

    assign load_hit = mask_reg[x_reg] && mask_reg[y_reg] && mask_reg[z_reg];
    assign swap_hit = mask_reg[a_reg] && mask_reg[b_reg];
    assign issue    = (state_reg == ST_LOAD) || (state_reg == ST_EVAL) ||
                      (state_reg == ST_APPLY);
    assign cnt_inc  = cnt_rd_data + COUNT_W'(1);
    assign cnt_dec  = cnt_rd_data - COUNT_W'(1);
    assign take_swap = dv_reg[DV_W-1] ||
                       ($signed(dv_reg) <= $signed({1'b0, limit_reg}));

    always_comb
    begin
        if ((state_reg == ST_LOAD) || (state_reg == ST_CLEAR))
        begin
            last_issue = (idx_reg == SLOT_W'(TRIPLE_DEPTH - 1));
        end
        else
        begin
            last_issue = (a_reg == ROW_W'(MAX_ROWS - 2)) &&
                         (b_reg == ROW_W'(MAX_ROWS - 1)) && sel_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (last_issue)
                begin
                    state_next = clr_res_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.op)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_LOAD:  state_next = loaded_reg[req.column] ? ST_DONE : ST_LOAD;
                        OP_SWAP:  state_next = ST_MASK;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_MASK:    state_next = swap_bad ? ST_DONE : ST_EVAL;
            ST_LOAD:    state_next = last_issue ? ST_DRAIN : ST_LOAD;
            ST_EVAL:    state_next = last_issue ? ST_EVDRAIN : ST_EVAL;
            ST_EVDRAIN: state_next = ST_DECIDE;
            ST_DECIDE:  state_next = take_swap ? ST_APPLY : ST_DONE;
            ST_APPLY:   state_next = last_issue ? ST_DRAIN : ST_APPLY;
            ST_DRAIN:   state_next = ST_DONE;
            ST_DONE:    state_next = res_ready ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        req_ready   = (state_reg == ST_IDLE);
        res_valid   = (state_reg == ST_DONE);
        cnt_rd_addr = (state_reg == ST_LOAD) ? idx_reg : swap_addr;
        cnt_wr_en   = 1'b0;
        cnt_wr_addr = p1_addr_reg;
        cnt_wr_data = cnt_inc;
        if (state_reg == ST_CLEAR)
        begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = idx_reg;
            cnt_wr_data = '0;
        end
        else if (p1_vld_reg && p1_hit_reg)
        begin
            if (op_reg == OP_LOAD)
            begin
                cnt_wr_en = 1'b1;
            end
            else if (apply_reg)
            begin
                cnt_wr_en   = 1'b1;
                cnt_wr_data = p1_sel_reg ? cnt_inc : cnt_dec;
            end
        end
        msk_wr_en   = 1'b0;
        msk_wr_addr = col_reg;
        msk_wr_data = (mask_reg & ~(MAX_ROWS'(1) << rout_reg)) | rin_bit;
        if (accept_req && (req.op == OP_LOAD) && !loaded_reg[req.column])
        begin
            msk_wr_en   = 1'b1;
            msk_wr_addr = req.column;
            msk_wr_data = req.mask & valid_rows;
        end
        else if ((state_reg == ST_DECIDE) && take_swap)
        begin
            msk_wr_en = 1'b1;
        end
        res.violations = total_reg;
        res.delta      = dv_reg[8:0];
        res.accepted   = acc_reg;
        res.status     = status_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            idx_reg     <= '0;
            clr_res_reg <= 1'b0;
            p1_vld_reg  <= 1'b0;
            loaded_reg  <= '0;
            total_reg   <= '0;
            apply_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            p1_vld_reg <= issue;

            // sweep counter for clear and load
            if ((state_reg == ST_CLEAR) || (state_reg == ST_LOAD))
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
            if (state_reg == ST_CLEAR)
            begin
                if (last_issue)
                begin
                    clr_res_reg <= 1'b0;
                end
            end

            if (accept_req)
            begin
                idx_reg   <= '0;
                apply_reg <= 1'b0;
                case (req.op)
                    OP_CLEAR:
                    begin
                        clr_res_reg <= 1'b1;
                        loaded_reg  <= '0;
                        total_reg   <= '0;
                    end
                    OP_LOAD:
                    begin
                        loaded_reg[req.column] <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // load count update raises the total past two
            if (p1_vld_reg && p1_hit_reg && (op_reg == OP_LOAD) &&
                (cnt_inc > COUNT_W'(2)))
            begin
                total_reg <= total_reg + TOTAL_W'(1);
            end

            if ((state_reg == ST_DECIDE) && take_swap)
            begin
                apply_reg <= 1'b1;
                total_reg <= total_reg + {{(TOTAL_W-DV_W){dv_reg[DV_W-1]}}, dv_reg};
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p1_addr_reg <= cnt_rd_addr;
        p1_sel_reg  <= sel_reg;
        p1_hit_reg  <= (state_reg == ST_LOAD) ? load_hit : swap_hit;

        if (accept_req)
        begin
            op_reg     <= req.op;
            col_reg    <= req.column;
            rout_reg   <= req.row_out;
            rin_reg    <= req.row_in;
            mask_reg   <= req.mask & valid_rows;
            limit_reg  <= req.accept_limit;
            dv_reg     <= '0;
            acc_reg    <= 1'b0;
            status_reg <= ((req.op == OP_LOAD) && loaded_reg[req.column]) ||
                          ((req.op != OP_CLEAR) && (req.op != OP_LOAD) &&
                           (req.op != OP_SWAP));
            x_reg      <= ROW_W'(0);
            y_reg      <= ROW_W'(1);
            z_reg      <= ROW_W'(2);
        end

        // triple walk in slot order
        if (state_reg == ST_LOAD)
        begin
            if (x_reg + ROW_W'(1) < y_reg)
            begin
                x_reg <= x_reg + ROW_W'(1);
            end
            else
            begin
                x_reg <= '0;
                if (y_reg + ROW_W'(1) < z_reg)
                begin
                    y_reg <= y_reg + ROW_W'(1);
                end
                else
                begin
                    y_reg <= ROW_W'(1);
                    z_reg <= z_reg + ROW_W'(1);
                end
            end
        end

        // swap check, rest mask kept in mask_reg
        if (state_reg == ST_MASK)
        begin
            status_reg <= swap_bad;
            mask_reg   <= col_mask & ~(MAX_ROWS'(1) << rout_reg);
            a_reg      <= ROW_W'(0);
            b_reg      <= ROW_W'(1);
            sel_reg    <= 1'b0;
        end

        // row pair walk, two counts per pair
        if ((state_reg == ST_EVAL) || (state_reg == ST_APPLY))
        begin
            if (!sel_reg)
            begin
                sel_reg <= 1'b1;
            end
            else
            begin
                sel_reg <= 1'b0;
                if (b_reg == ROW_W'(MAX_ROWS - 1))
                begin
                    a_reg <= a_reg + ROW_W'(1);
                    b_reg <= a_reg + ROW_W'(2);
                end
                else
                begin
                    b_reg <= b_reg + ROW_W'(1);
                end
            end
        end

        // violation change of the proposal
        if (p1_vld_reg && p1_hit_reg && (op_reg == OP_SWAP) && !apply_reg)
        begin
            if (!p1_sel_reg && (cnt_rd_data >= COUNT_W'(3)))
            begin
                dv_reg <= dv_reg - DV_W'(1);
            end
            else if (p1_sel_reg && (cnt_rd_data >= COUNT_W'(2)))
            begin
                dv_reg <= dv_reg + DV_W'(1);
            end
        end

        if (state_reg == ST_DECIDE)
        begin
            a_reg   <= ROW_W'(0);
            b_reg   <= ROW_W'(1);
            sel_reg <= 1'b0;
            acc_reg <= take_swap;
        end
    end

endmodule

// ----- dv/tb_triple_coverage_swap_evaluator.sv -----
// ----------------------------------------------------------------------------
// tb_triple_coverage_swap_evaluator
// Self-checking bench: directed and random requests of every operation under
// several row counts, checked against a coverage store kept in the bench
// ----------------------------------------------------------------------------
module tb_triple_coverage_swap_evaluator;

    import tcs_pkg::*;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        logic [1:0]  op;
        logic [55:0] data;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;

    // requests waiting to be offered and results waiting to arrive
    request_t request_q[$];
    tcs_res_t result_q[$];

    // coverage store as the bench sees it
    logic [23:0] col_mask[32];
    logic        col_loaded[32];
    logic [5:0]  cover_count[TRIPLE_DEPTH];
    logic [15:0] excess_total;
    logic [4:0]  row_limit;

    // shadow used only to steer generation toward legal swaps
    logic [23:0] gen_mask[32];
    logic        gen_loaded[32];
    int          gen_rows;

    int  mismatches;
    int  accepted_requests;
    int  hold_left;
    bit  hold_done;
    bit  no_idle;
    bit  s_fire;

    triple_coverage_swap_evaluator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // slot of an unordered triple of distinct rows
    function automatic int triple_index(int x, int y, int z);
        int t;
        if (x > y) begin t = x; x = y; y = t; end
        if (y > z) begin t = y; y = z; z = t; end
        if (x > y) begin t = x; x = y; y = t; end
        t = z * (z - 1) * (z - 2) / 6 + y * (y - 1) / 2 + x;
        return (t < TRIPLE_DEPTH) ? t : 0;
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < 32; i++)
        begin
            col_mask[i]   = '0;
            col_loaded[i] = 1'b0;
        end
        for (int i = 0; i < TRIPLE_DEPTH; i++)
            cover_count[i] = '0;
        excess_total = '0;
    endfunction

    // apply one request to the store and return the result it produces
    function automatic tcs_res_t apply_request(logic [1:0] op, logic [55:0] d);
        tcs_res_t    r;
        int          col, rout, rin, lim, rows, dv, s1, s2;
        logic [23:0] m, rest, valid;
        col  = d[4:0];
        rout = d[9:5];
        rin  = d[14:10];
        m    = d[38:15];
        lim  = d[54:39];
        rows = (row_limit > MAX_ROWS) ? MAX_ROWS : row_limit;
        valid = (24'd1 << rows) - 24'd1;
        if (rows >= 24)
            valid = '1;
        dv = 0;
        r  = '0;
        if (op == OP_CLEAR)
            wipe_store();
        else if (op == OP_LOAD)
        begin
            if (col_loaded[col])
                r.status = 1'b1;
            else
            begin
                m = m & valid;
                col_mask[col]   = m;
                col_loaded[col] = 1'b1;
                for (int a = 0; a < 24; a++)
                    for (int b = a + 1; b < 24; b++)
                        for (int c = b + 1; c < 24; c++)
                            if (m[a] && m[b] && m[c])
                            begin
                                s1 = triple_index(a, b, c);
                                cover_count[s1] = cover_count[s1] + 6'd1;
                                if (cover_count[s1] > 6'd2)
                                    excess_total = excess_total + 16'd1;
                            end
            end
        end
        else if (op == OP_SWAP)
        begin
            m = col_mask[col];
            if (rout >= rows || rin >= rows || !m[rout] || m[rin])
                r.status = 1'b1;
            else
            begin
                rest = m;
                rest[rout] = 1'b0;
                // evaluate the move
                for (int a = 0; a < 24; a++)
                    for (int b = a + 1; b < 24; b++)
                        if (rest[a] && rest[b])
                        begin
                            if (cover_count[triple_index(a, b, rout)] >= 6'd3)
                                dv--;
                            if (cover_count[triple_index(a, b, rin)] >= 6'd2)
                                dv++;
                        end
                if (dv <= lim)
                begin
                    r.accepted = 1'b1;
                    for (int a = 0; a < 24; a++)
                        for (int b = a + 1; b < 24; b++)
                            if (rest[a] && rest[b])
                            begin
                                s1 = triple_index(a, b, rout);
                                s2 = triple_index(a, b, rin);
                                cover_count[s1] = cover_count[s1] - 6'd1;
                                cover_count[s2] = cover_count[s2] + 6'd1;
                            end
                    rest[rin] = 1'b1;
                    col_mask[col] = rest;
                    excess_total = excess_total + 16'(dv);
                end
                r.delta = 9'(dv);
            end
        end
        else
            r.status = 1'b1;
        r.violations = excess_total;
        return r;
    endfunction

    // queue one request and track what the generator expects the store to hold
    task automatic push_request(int op, int col, int rout, int rin, int m, int lim);
        request_t    q;
        logic [23:0] valid;
        q.op   = op[1:0];
        q.data = {1'b0, lim[15:0], m[23:0], rin[4:0], rout[4:0], col[4:0]};
        request_q.push_back(q);
        valid = (gen_rows >= 24) ? 24'hFFFFFF : ((24'd1 << gen_rows) - 24'd1);
        if (op == OP_CLEAR)
            for (int i = 0; i < 32; i++)
            begin
                gen_mask[i]   = '0;
                gen_loaded[i] = 1'b0;
            end
        else if (op == OP_LOAD && !gen_loaded[col[4:0]])
        begin
            gen_loaded[col[4:0]] = 1'b1;
            gen_mask[col[4:0]]   = m[23:0] & valid;
        end
        else if (op == OP_SWAP && rout < gen_rows && rin < gen_rows &&
                 gen_mask[col[4:0]][rout] && !gen_mask[col[4:0]][rin] && lim >= 253)
        begin
            gen_mask[col[4:0]][rout] = 1'b0;
            gen_mask[col[4:0]][rin]  = 1'b1;
        end
    endtask

    // wait until every request has been offered and answered
    task automatic wait_idle();
        while (request_q.size() != 0 || s_axis_tvalid || result_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_row_count(int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[4:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        row_limit = value[4:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // swap steered toward a loaded column and legal rows, random content
    task automatic push_legal_swap();
        int col, rout, rin, lim, tries;
        col = $urandom_range(0, 31);
        for (tries = 0; tries < 8 && gen_mask[col] == 0; tries++)
            col = $urandom_range(0, 31);
        rout = $urandom_range(0, 23);
        for (tries = 0; tries < 40 && !(rout < gen_rows && gen_mask[col][rout]); tries++)
            rout = $urandom_range(0, 23);
        rin = $urandom_range(0, 23);
        for (tries = 0; tries < 40 && !(rin < gen_rows && !gen_mask[col][rin]); tries++)
            rin = $urandom_range(0, 23);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: lim = $urandom_range(253, 65535);
            5, 6, 7:       lim = $urandom_range(0, 3);
            default:       lim = $urandom;
        endcase
        push_request(OP_SWAP, col, rout, rin, $urandom, lim);
    endtask

    // one phase of random traffic under the current row count
    task automatic random_phase(int count);
        int kind;
        push_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        repeat ($urandom_range(6, 12))
            push_request(OP_LOAD, $urandom_range(0, 31), $urandom, $urandom,
                         $urandom | $urandom, $urandom);
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
                push_legal_swap();
            else if (kind < 85)
                push_request(OP_LOAD, $urandom_range(0, 31), $urandom, $urandom,
                             $urandom, $urandom);
            else if (kind < 87)
                push_request(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                push_request($urandom_range(2, 3), $urandom, $urandom, $urandom,
                             $urandom, $urandom);
        end
    endtask

    // request handshake seen at the rising edge: predict and record
    always @(posedge clk)
    begin
        s_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            result_q.push_back(apply_request(s_axis_tuser, s_axis_tdata));
            accepted_requests <= accepted_requests + 1;
        end
    end

    // request driver
    always @(negedge clk)
    begin
        request_t q;
        if (!s_axis_tvalid || s_fire)
        begin
            if (request_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 13))
            begin
                q = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= q.data;
                s_axis_tuser  <= q.op;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result ready, with one long hold-off while plenty of traffic is pending
    always @(negedge clk)
    begin
        if (!hold_done && accepted_requests >= 150)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 13);
    end

    // result monitor
    always @(posedge clk)
    begin
        tcs_res_t want, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.violations = m_axis_tdata[15:0];
            got.delta      = m_axis_tdata[24:16];
            got.accepted   = m_axis_tdata[25];
            got.status     = m_axis_tdata[26];
            if (result_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end
            else
            begin
                want = result_q.pop_front();
                if (got.violations !== want.violations || got.delta !== want.delta ||
                    got.accepted !== want.accepted || got.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected viol %0d delta %0d acc %b st %b,",
                                  " got viol %0d delta %0d acc %b st %b"},
                                 want.violations, $signed(want.delta), want.accepted,
                                 want.status, got.violations, $signed(got.delta),
                                 got.accepted, got.status);
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_fire = 1'b0;
        mismatches = 0;
        accepted_requests = 0;
        hold_left = 0;
        hold_done = 1'b0;
        no_idle = 1'b0;
        row_limit = 5'd24;
        gen_rows = 24;
        wipe_store();
        for (int i = 0; i < 32; i++)
        begin
            gen_mask[i] = '0;
            gen_loaded[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: full columns overlap, reloads, every kind of bad swap
        push_request(OP_CLEAR, 0, 0, 0, 0, 0);
        push_request(OP_LOAD, 0, 0, 0, 24'hFFFFFF, 0);
        push_request(OP_LOAD, 1, 0, 0, 24'hFFFFFF, 0);
        push_request(OP_LOAD, 2, 0, 0, 24'h7FFFFE, 0);
        push_request(OP_LOAD, 0, 0, 0, 24'h000007, 0);
        push_request(OP_LOAD, 31, 31, 31, 24'h000000, 16'hFFFF);
        push_request(OP_LOAD, 3, 0, 0, 24'h00000F, 0);
        push_request(OP_SWAP, 2, 24, 0, 0, 16'hFFFF);
        push_request(OP_SWAP, 2, 1, 31, 0, 16'hFFFF);
        push_request(OP_SWAP, 3, 5, 6, 0, 16'hFFFF);
        push_request(OP_SWAP, 3, 0, 1, 0, 16'hFFFF);
        push_request(OP_SWAP, 3, 2, 2, 0, 16'hFFFF);
        push_request(OP_SWAP, 2, 1, 0, 0, 0);
        push_request(OP_SWAP, 2, 1, 0, 0, 16'hFFFF);
        push_request(OP_SWAP, 2, 0, 1, 24'hFFFFFF, 0);
        push_request(OP_SWAP, 3, 3, 23, 0, 16'h8000);
        push_request(OP_UNKNOWN, 31, 31, 31, 24'hFFFFFF, 16'hFFFF);
        push_request(OP_CLEAR, 31, 31, 31, 24'hFFFFFF, 16'hFFFF);
        push_request(OP_LOAD, 0, 0, 0, 24'hFFFFFF, 0);
        wait_idle();

        // random phases across row counts, extremes included
        random_phase(90);
        wait_idle();
        write_row_count(3);
        gen_rows = 3;
        random_phase(60);
        wait_idle();
        write_row_count(31);
        gen_rows = 24;
        no_idle = 1'b1;
        random_phase(90);
        wait_idle();
        no_idle = 1'b0;
        write_row_count(2);
        gen_rows = 2;
        random_phase(30);
        wait_idle();
        write_row_count(10);
        gen_rows = 10;
        random_phase(70);
        // row count changed over live contents
        wait_idle();
        write_row_count(24);
        gen_rows = 24;
        for (int i = 0; i < 60; i++)
            push_legal_swap();
        wait_idle();

        if (mismatches == 0 && result_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // run limit
    initial
    begin
        #40000000;
        $display("simulation failed");
        $finish;
    end

endmodule
